// ===== rtl/ecdsa_der_signature_encoder_assert.svh =====
// Assertion helpers for the signature encoder.
`ifndef ECDSA_DER_SIGNATURE_ENCODER_ASSERT_SVH
`define ECDSA_DER_SIGNATURE_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define EDSE_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("edse: same-cycle check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define EDSE_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("edse: next-cycle check failed");

`endif

// ===== rtl/edse_pkg.sv =====
`timescale 1ns / 1ps

package edse_pkg;

   localparam int MEM_DEPTH = 97;
   localparam int OUT_BYTES = 8;

   localparam logic [6:0] SIG_BYTES    = 7'd64;
   localparam logic [6:0] TOTAL_BYTES  = 7'd97;
   localparam logic [6:0] R_LAST_ADDR  = 7'd31;
   localparam logic [6:0] S_LAST_ADDR  = 7'd63;
   localparam logic [6:0] K_FIRST_ADDR = 7'd64;
   localparam logic [6:0] K_LAST_ADDR  = 7'd96;

   localparam logic [7:0] SEQ_TAG      = 8'h30;
   localparam logic [7:0] INT_TAG      = 8'h02;
   localparam logic [7:0] ZERO_BYTE    = 8'h00;
   localparam logic [7:0] KEY_LEN_BYTE = 8'h21;

   localparam logic [1:0] CSR_SIGHASH = 2'd0;
   localparam logic [1:0] CSR_FORMAT  = 2'd1;

   localparam logic [255:0] CURVE_ORDER =
      256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_BAAEDCE6_AF48A03B_BFD25E8C_D0364141;
   localparam logic [255:0] HALF_ORDER =
      256'h7FFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_5D576E73_57A4501D_DFE92F46_681B20A0;

   typedef enum logic [2:0] {
      SC_NONE,
      SC_CMP,
      SC_NEG,
      SC_LZR,
      SC_LZS
   } scan_type;

   typedef enum logic [3:0] {
      EM_NONE,
      EM_INT,
      EM_DERLEN,
      EM_SEQ,
      EM_SEQLEN,
      EM_RLEN,
      EM_SLEN,
      EM_ZERO,
      EM_HASH,
      EM_KLEN,
      EM_MEM
   } emit_type;

   typedef struct packed {
      scan_type scan;
      logic     store;
      logic     cnt_inc;
      logic     cnt_clr;
      logic     err;
      emit_type em;
      logic     em_last;
   } cmd_type;

   typedef struct packed {
      logic over;
      logic final_byte;
      logic witness;
      logic scan_done;
      logic zero_r;
      logic pad_r;
      logic zero_s;
      logic pad_s;
      logic body_end;
   } status_type;

   // byte i of the order, big-endian
   function automatic logic [7:0] order_byte(input logic [4:0] i);
      logic [7:0] b;
      b = CURVE_ORDER[{~i, 3'b000} +: 8];
      return b;
   endfunction

   function automatic logic [7:0] half_byte(input logic [4:0] i);
      logic [7:0] b;
      b = HALF_ORDER[{~i, 3'b000} +: 8];
      return b;
   endfunction

endpackage

// ===== rtl/edse_ctrl.sv =====
`timescale 1ns / 1ps

module edse_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_in_last,
   input  edse_pkg::status_type status,
   output logic                 busy,
   output edse_pkg::cmd_type    cmd
);

   typedef enum logic [20:0] {
      ST_IDLE   = 21'h000001,
      ST_CMP    = 21'h000002,
      ST_NEG    = 21'h000004,
      ST_LZR    = 21'h000008,
      ST_LZS    = 21'h000010,
      ST_WCNT   = 21'h000020,
      ST_WLEN   = 21'h000040,
      ST_SEQ    = 21'h000080,
      ST_SEQLEN = 21'h000100,
      ST_RTAG   = 21'h000200,
      ST_RLEN   = 21'h000400,
      ST_RPAD   = 21'h000800,
      ST_RBODY  = 21'h001000,
      ST_STAG   = 21'h002000,
      ST_SLEN   = 21'h004000,
      ST_SPAD   = 21'h008000,
      ST_SBODY  = 21'h010000,
      ST_HASH   = 21'h020000,
      ST_KLEN   = 21'h040000,
      ST_KBODY  = 21'h080000,
      ST_DRAIN  = 21'h100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (status.over) begin
                  cmd.err     = 1'b1;
                  cmd.cnt_clr = 1'b1;
               end else begin
                  cmd.store = 1'b1;
                  if (!status.final_byte) begin
                     if (req_in_last) begin
                        cmd.err     = 1'b1;
                        cmd.cnt_clr = 1'b1;
                     end else begin
                        cmd.cnt_inc = 1'b1;
                     end
                  end else begin
                     cmd.cnt_clr = 1'b1;
                     if (!req_in_last) begin
                        cmd.err = 1'b1;
                     end else begin
                        state_in = ST_CMP;
                     end
                  end
               end
            end
         end
         ST_CMP: begin
            cmd.scan = edse_pkg::SC_CMP;
            if (status.scan_done) state_in = ST_NEG;
         end
         ST_NEG: begin
            cmd.scan = edse_pkg::SC_NEG;
            if (status.scan_done) state_in = ST_LZR;
         end
         ST_LZR: begin
            cmd.scan = edse_pkg::SC_LZR;
            if (status.scan_done) state_in = ST_LZS;
         end
         ST_LZS: begin
            cmd.scan = edse_pkg::SC_LZS;
            if (status.scan_done) state_in = status.witness ? ST_WCNT : ST_SEQ;
         end
         ST_WCNT: begin
            cmd.em   = edse_pkg::EM_INT;
            state_in = ST_WLEN;
         end
         ST_WLEN: begin
            cmd.em   = edse_pkg::EM_DERLEN;
            state_in = ST_SEQ;
         end
         ST_SEQ: begin
            cmd.em   = edse_pkg::EM_SEQ;
            state_in = ST_SEQLEN;
         end
         ST_SEQLEN: begin
            cmd.em   = edse_pkg::EM_SEQLEN;
            state_in = ST_RTAG;
         end
         ST_RTAG: begin
            cmd.em   = edse_pkg::EM_INT;
            state_in = ST_RLEN;
         end
         ST_RLEN: begin
            cmd.em   = edse_pkg::EM_RLEN;
            state_in = (status.zero_r || status.pad_r) ? ST_RPAD : ST_RBODY;
         end
         ST_RPAD: begin
            cmd.em   = edse_pkg::EM_ZERO;
            state_in = status.zero_r ? ST_STAG : ST_RBODY;
         end
         ST_RBODY: begin
            cmd.em = edse_pkg::EM_MEM;
            if (status.body_end) state_in = ST_STAG;
         end
         ST_STAG: begin
            cmd.em   = edse_pkg::EM_INT;
            state_in = ST_SLEN;
         end
         ST_SLEN: begin
            cmd.em   = edse_pkg::EM_SLEN;
            state_in = (status.zero_s || status.pad_s) ? ST_SPAD : ST_SBODY;
         end
         ST_SPAD: begin
            cmd.em   = edse_pkg::EM_ZERO;
            state_in = status.zero_s ? ST_HASH : ST_SBODY;
         end
         ST_SBODY: begin
            cmd.em = edse_pkg::EM_MEM;
            if (status.body_end) state_in = ST_HASH;
         end
         ST_HASH: begin
            cmd.em      = edse_pkg::EM_HASH;
            cmd.em_last = !status.witness;
            state_in    = status.witness ? ST_KLEN : ST_DRAIN;
         end
         ST_KLEN: begin
            cmd.em   = edse_pkg::EM_KLEN;
            state_in = ST_KBODY;
         end
         ST_KBODY: begin
            cmd.em = edse_pkg::EM_MEM;
            if (status.body_end) begin
               cmd.em_last = 1'b1;
               state_in    = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/edse_dpath.sv =====
`timescale 1ns / 1ps

module edse_dpath #(
   parameter int BYTES_PER_RESULT = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  edse_pkg::cmd_type    cmd,
   output edse_pkg::status_type status,
   input  logic [7:0]           req_in_byte,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [7:0]           csr_data,
   output logic                 rsp_strobe,
   output logic [63:0]          rsp_out_bytes,
   output logic [3:0]           rsp_out_count,
   output logic                 rsp_out_last,
   output logic                 rsp_out_error
);

   // configuration
   logic [7:0] sighash_ff;
   logic       fmt_ff;

   // load counter
   logic [6:0] cnt_ff;
   logic [6:0] cnt_in;
   logic [6:0] expected;

   // byte store: r at 0..31, s at 32..63, key at 64..96
   logic [7:0] mem [0:edse_pkg::MEM_DEPTH-1];
   logic       wr_en;
   logic [6:0] wr_addr;
   logic [7:0] wr_data;
   logic [6:0] rd_addr;
   logic [7:0] rd_data_ff;

   // scan sequencer
   logic       scanning;
   logic       issue;
   logic       done;
   logic [5:0] step_ff;
   logic [4:0] pos_ff;
   logic       pvld_ff;

   // s compare and negate
   logic       dec_ff, gt_ff, flip_ff, borrow_ff;
   logic       dec_n, gt_n, borrow_in, neg_we;
   logic [7:0] half_b;
   logic [8:0] diff;

   // leading-zero scan
   logic       fnd_ff, pad_ff, fnd_n, pad_n;
   logic [4:0] lead_ff, lead_n;
   logic       zero_r_ff, pad_r_ff, zero_s_ff, pad_s_ff;
   logic [4:0] lead_r_ff, lead_s_ff;

   // emission
   logic [5:0] len_r, len_s;
   logic [6:0] der_len;
   logic [6:0] eaddr_ff;
   logic [6:0] eaddr_in;
   logic [7:0] cst_byte;
   logic       em_vld_ff, em_mem_ff, em_last_ff;
   logic [7:0] em_cst_ff;
   logic [7:0] byte_v;
   logic [63:0] acc_ff, acc_n;
   logic [3:0]  acc_cnt_ff;
   logic        flush;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         sighash_ff <= 8'd1;
         fmt_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            edse_pkg::CSR_SIGHASH: sighash_ff <= csr_data;
            edse_pkg::CSR_FORMAT:  fmt_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // ---------------- load counter ----------------
   assign expected = fmt_ff ? edse_pkg::TOTAL_BYTES : edse_pkg::SIG_BYTES;

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // ---------------- scan sequencer ----------------
   assign scanning = (cmd.scan != edse_pkg::SC_NONE);
   assign issue    = scanning && !step_ff[5];
   assign done     = pvld_ff && (pos_ff == 5'd31);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         pvld_ff <= 1'b0;
      end else begin
         pvld_ff <= issue;
         if (done) begin
            step_ff <= '0;
         end else if (issue) begin
            step_ff <= step_ff + 6'd1;
         end
      end
      pos_ff <= step_ff[4:0];
   end

   always_comb begin
      unique case (cmd.scan) inside
         edse_pkg::SC_CMP, edse_pkg::SC_LZS: rd_addr = {2'b01, step_ff[4:0]};
         edse_pkg::SC_NEG:                   rd_addr = {2'b01, ~step_ff[4:0]};
         edse_pkg::SC_LZR:                   rd_addr = {2'b00, step_ff[4:0]};
         default:                            rd_addr = eaddr_ff;
      endcase
   end

   // ---------------- s > n/2 compare ----------------
   assign half_b = edse_pkg::half_byte(pos_ff);
   assign dec_n  = dec_ff || (rd_data_ff != half_b);
   assign gt_n   = dec_ff ? gt_ff : (rd_data_ff > half_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff  <= 1'b0;
         gt_ff   <= 1'b0;
         flip_ff <= 1'b0;
      end else if (pvld_ff && cmd.scan == edse_pkg::SC_CMP) begin
         if (done) begin
            flip_ff <= gt_n;
            dec_ff  <= 1'b0;
            gt_ff   <= 1'b0;
         end else begin
            dec_ff <= dec_n;
            gt_ff  <= gt_n;
         end
      end
   end

   // ---------------- s <- n - s, low byte first ----------------
   assign borrow_in = (pos_ff == 5'd0) ? 1'b0 : borrow_ff;
   assign diff      = {1'b0, edse_pkg::order_byte(~pos_ff)} - {1'b0, rd_data_ff}
                      - {8'd0, borrow_in};
   assign neg_we    = pvld_ff && (cmd.scan == edse_pkg::SC_NEG) && flip_ff;

   always_ff @(posedge clock) begin
      borrow_ff <= diff[8];
   end

   // ---------------- store ----------------
   assign wr_en   = cmd.store || neg_we;
   assign wr_addr = neg_we ? {2'b01, ~pos_ff} : cnt_ff;
   assign wr_data = neg_we ? diff[7:0] : req_in_byte;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // ---------------- leading-zero scan ----------------
   assign fnd_n  = fnd_ff || (rd_data_ff != 8'd0);
   assign lead_n = fnd_ff ? lead_ff : pos_ff;
   assign pad_n  = fnd_ff ? pad_ff : rd_data_ff[7];

   always_ff @(posedge clock) begin
      if (reset) begin
         fnd_ff    <= 1'b0;
         zero_r_ff <= 1'b0;
         pad_r_ff  <= 1'b0;
         zero_s_ff <= 1'b0;
         pad_s_ff  <= 1'b0;
      end else if (pvld_ff &&
                   (cmd.scan == edse_pkg::SC_LZR || cmd.scan == edse_pkg::SC_LZS)) begin
         if (done) begin
            fnd_ff <= 1'b0;
            if (cmd.scan == edse_pkg::SC_LZR) begin
               zero_r_ff <= !fnd_n;
               pad_r_ff  <= pad_n;
            end else begin
               zero_s_ff <= !fnd_n;
               pad_s_ff  <= pad_n;
            end
         end else begin
            fnd_ff <= fnd_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      lead_ff <= lead_n;
      pad_ff  <= pad_n;
      if (done && cmd.scan == edse_pkg::SC_LZR) lead_r_ff <= lead_n;
      if (done && cmd.scan == edse_pkg::SC_LZS) lead_s_ff <= lead_n;
   end

   // ---------------- byte generator ----------------
   assign len_r   = zero_r_ff ? 6'd1 : (6'd32 - {1'b0, lead_r_ff} + {5'd0, pad_r_ff});
   assign len_s   = zero_s_ff ? 6'd1 : (6'd32 - {1'b0, lead_s_ff} + {5'd0, pad_s_ff});
   assign der_len = 7'd7 + {1'b0, len_r} + {1'b0, len_s};

   always_comb begin
      unique case (cmd.em)
         edse_pkg::EM_INT:    cst_byte = edse_pkg::INT_TAG;
         edse_pkg::EM_DERLEN: cst_byte = {1'b0, der_len};
         edse_pkg::EM_SEQ:    cst_byte = edse_pkg::SEQ_TAG;
         edse_pkg::EM_SEQLEN: cst_byte = {1'b0, der_len - 7'd2};
         edse_pkg::EM_RLEN:   cst_byte = {2'b00, len_r};
         edse_pkg::EM_SLEN:   cst_byte = {2'b00, len_s};
         edse_pkg::EM_HASH:   cst_byte = sighash_ff;
         edse_pkg::EM_KLEN:   cst_byte = edse_pkg::KEY_LEN_BYTE;
         default:             cst_byte = edse_pkg::ZERO_BYTE;
      endcase
   end

   always_comb begin
      unique case (cmd.em)
         edse_pkg::EM_RLEN: eaddr_in = {2'b00, lead_r_ff};
         edse_pkg::EM_SLEN: eaddr_in = {2'b01, lead_s_ff};
         edse_pkg::EM_KLEN: eaddr_in = edse_pkg::K_FIRST_ADDR;
         edse_pkg::EM_MEM:  eaddr_in = eaddr_ff + 7'd1;
         default:           eaddr_in = eaddr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_vld_ff  <= 1'b0;
         em_last_ff <= 1'b0;
      end else begin
         em_vld_ff  <= (cmd.em != edse_pkg::EM_NONE);
         em_last_ff <= cmd.em_last;
      end
      eaddr_ff  <= eaddr_in;
      em_mem_ff <= (cmd.em == edse_pkg::EM_MEM);
      em_cst_ff <= cst_byte;
   end

   // ---------------- beat packer ----------------
   assign byte_v = em_mem_ff ? rd_data_ff : em_cst_ff;
   assign flush  = em_last_ff || ((acc_cnt_ff + 4'd1) == 4'(BYTES_PER_RESULT));

   always_comb begin
      acc_n = acc_ff;
      for (int i = 0; i < edse_pkg::OUT_BYTES; i++) begin
         if (acc_cnt_ff == 4'(i)) acc_n[63 - 8*i -: 8] = byte_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         acc_cnt_ff <= '0;
      end else if (em_vld_ff) begin
         if (flush) begin
            acc_ff     <= '0;
            acc_cnt_ff <= '0;
         end else begin
            acc_ff     <= acc_n;
            acc_cnt_ff <= acc_cnt_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= cmd.err || (em_vld_ff && flush);
      end
      if (cmd.err) begin
         rsp_out_bytes <= '0;
         rsp_out_count <= '0;
         rsp_out_last  <= 1'b1;
         rsp_out_error <= 1'b1;
      end else begin
         rsp_out_bytes <= acc_n;
         rsp_out_count <= acc_cnt_ff + 4'd1;
         rsp_out_last  <= em_last_ff;
         rsp_out_error <= 1'b0;
      end
   end

   // ---------------- status ----------------
   assign status.over       = (cnt_ff >= expected);
   assign status.final_byte = ((cnt_ff + 7'd1) == expected);
   assign status.witness    = fmt_ff;
   assign status.scan_done  = done;
   assign status.zero_r     = zero_r_ff;
   assign status.pad_r      = pad_r_ff;
   assign status.zero_s     = zero_s_ff;
   assign status.pad_s      = pad_s_ff;
   assign status.body_end   = (eaddr_ff == edse_pkg::R_LAST_ADDR) ||
                              (eaddr_ff == edse_pkg::S_LAST_ADDR) ||
                              (eaddr_ff == edse_pkg::K_LAST_ADDR);

endmodule

// ===== rtl/ecdsa_der_signature_encoder.sv =====
`timescale 1ns / 1ps
// DER signature encoder with low-s normalization.
// Input: one byte per beat on req_in_byte, taken when start is high and busy low.
//   A load is r then s (64 bytes), plus 33 key bytes when output_format is 1;
//   req_in_last marks the final byte. Non-final bytes load at one per cycle.
// Config: csr_index 0 = sighash byte, 1 = output format; written on csr_valid
//   and csr_ready, csr_ready is low while busy.
// Output: rsp_strobe marks each result for exactly one cycle; the receiver
//   cannot stall. Bytes are left-aligned, up to BYTES_PER_RESULT per beat.
// A wrong load length gives one error beat in the cycle after the offending
//   byte is taken; busy stays low and the next load starts at once.
// After the final byte busy stays high while the block makes four passes
//   over the 32-byte s / r fields through the single store read port and
//   then emits the encoded bytes (at most 73 plain, 109 witness) at one
//   output byte per cycle. The last beat is registered in em_vld_ff and then
//   rsp_strobe after the last byte is generated, and appears just as busy drops.
// Reset clears the load counter and sets sighash to 0x01, plain format.
`include "ecdsa_der_signature_encoder_assert.svh"

module ecdsa_der_signature_encoder #(
   parameter int BYTES_PER_RESULT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_strobe,
   output logic [63:0] rsp_out_bytes,
   output logic [3:0]  rsp_out_count,
   output logic        rsp_out_last,
   output logic        rsp_out_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   edse_pkg::cmd_type    cmd;
   edse_pkg::status_type status;
   logic                 csr_we;

   assign csr_ready = !busy;
   assign csr_we    = csr_valid && csr_ready;

   edse_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_in_last (req_in_last),
      .status      (status),
      .busy        (busy),
      .cmd         (cmd)
   );

   edse_dpath #(
      .BYTES_PER_RESULT (BYTES_PER_RESULT)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_in_byte   (req_in_byte),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_bytes (rsp_out_bytes),
      .rsp_out_count (rsp_out_count),
      .rsp_out_last  (rsp_out_last),
      .rsp_out_error (rsp_out_error)
   );

   `EDSE_ASSERT_NEXT(a_err_beat, cmd.err, rsp_strobe && rsp_out_error && rsp_out_last)
   `EDSE_ASSERT_NOW(a_err_src, rsp_strobe && rsp_out_error, $past(start && !busy))
   `EDSE_ASSERT_NOW(a_emit_busy, cmd.em != edse_pkg::EM_NONE, busy)
   `EDSE_ASSERT_NOW(a_beat_cnt, rsp_strobe && !rsp_out_error, (rsp_out_count != 4'd0) && (rsp_out_count <= 4'(BYTES_PER_RESULT)))

endmodule

// ===== tb/ecdsa_der_signature_encoder_checker.sv =====
`timescale 1ns / 1ps

module ecdsa_der_signature_encoder_checker #(
   parameter int BYTES_PER_RESULT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   input  logic        rsp_strobe,
   input  logic [63:0] rsp_out_bytes,
   input  logic [3:0]  rsp_out_count,
   input  logic        rsp_out_last,
   input  logic        rsp_out_error,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   output int          fail_count,
   output int          pending
);

   localparam int SIG_LEN = 64;
   localparam int KEY_LEN = 33;
   localparam logic [7:0] WITNESS_ITEMS = 8'h02;
   localparam logic [7:0] ONE_BYTE_LEN = 8'h01;

   typedef struct packed {
      logic [63:0] bytes;
      logic [3:0]  count;
      logic        last;
      logic        error;
   } beat_type;

   beat_type   expected_beats[$];
   logic [7:0] sig_mem[0:SIG_LEN-1];
   logic [7:0] key_mem[0:KEY_LEN-1];
   logic [7:0] enc_buf[0:127];
   int         enc_len;
   int         load_count;
   logic [7:0] sighash;
   logic       witness;

   function automatic void append_byte(input logic [7:0] b);
      enc_buf[enc_len] = b;
      enc_len++;
   endfunction

   function automatic void append_integer(input logic [255:0] v);
      int   lead;
      logic pad;
      lead = 0;
      while (lead < 32 && v[255-8*lead -: 8] == 8'h00) lead++;
      append_byte(edse_pkg::INT_TAG);
      if (lead == 32) begin
         append_byte(ONE_BYTE_LEN);
         append_byte(edse_pkg::ZERO_BYTE);
         return;
      end
      pad = v[255-8*lead];
      append_byte(8'(32 - lead + int'(pad)));
      if (pad) append_byte(edse_pkg::ZERO_BYTE);
      for (int i = lead; i < 32; i++) append_byte(v[255-8*i -: 8]);
   endfunction

   function automatic void push_error_beat();
      beat_type e;
      e.bytes = '0;
      e.count = '0;
      e.last  = 1'b1;
      e.error = 1'b1;
      expected_beats.push_back(e);
   endfunction

   function automatic void absorb_byte(input logic [7:0] b, input logic last);
      int           limit;
      int           idx;
      int           der_start;
      int           n;
      logic [255:0] r_val;
      logic [255:0] s_val;
      beat_type     e;
      limit = witness ? SIG_LEN + KEY_LEN : SIG_LEN;
      idx = load_count;
      if (idx >= limit) begin
         load_count = 0;
         push_error_beat();
         return;
      end
      if (idx < SIG_LEN) sig_mem[idx] = b;
      else if (idx - SIG_LEN < KEY_LEN) key_mem[idx-SIG_LEN] = b;
      if (idx + 1 < limit) begin
         if (last) begin
            load_count = 0;
            push_error_beat();
         end else begin
            load_count = idx + 1;
         end
         return;
      end
      load_count = 0;
      if (!last) begin
         push_error_beat();
         return;
      end

      for (int i = 0; i < 32; i++) begin
         r_val[255-8*i -: 8] = sig_mem[i];
         s_val[255-8*i -: 8] = sig_mem[32+i];
      end
      if (s_val > edse_pkg::HALF_ORDER) s_val = edse_pkg::CURVE_ORDER - s_val;

      enc_len = 0;
      if (witness) begin
         append_byte(WITNESS_ITEMS);
         append_byte(8'h00);
      end
      der_start = enc_len;
      append_byte(edse_pkg::SEQ_TAG);
      append_byte(8'h00);
      append_integer(r_val);
      append_integer(s_val);
      append_byte(sighash);
      enc_buf[der_start+1] = 8'(enc_len - der_start - 2);
      if (witness) begin
         enc_buf[1] = 8'(enc_len - der_start);
         append_byte(edse_pkg::KEY_LEN_BYTE);
         for (int i = 0; i < KEY_LEN; i++) append_byte(key_mem[i]);
      end

      for (int p = 0; p < enc_len; p += BYTES_PER_RESULT) begin
         n = enc_len - p;
         if (n > BYTES_PER_RESULT) n = BYTES_PER_RESULT;
         e.bytes = '0;
         for (int i = 0; i < n; i++) e.bytes[63-8*i -: 8] = enc_buf[p+i];
         e.count = 4'(n);
         e.last  = (p + n >= enc_len);
         e.error = 1'b0;
         expected_beats.push_back(e);
      end
   endfunction

   always @(posedge clock) begin
      beat_type e;
      if (reset) begin
         load_count = 0;
         sighash    = 8'h01;
         witness    = 1'b0;
         fail_count = 0;
         expected_beats.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_beats.size() == 0) begin
               $display("%0t: result beat with none expected: bytes %h count %0d last %b error %b",
                  $time, rsp_out_bytes, rsp_out_count, rsp_out_last, rsp_out_error);
               fail_count++;
            end else begin
               e = expected_beats.pop_front();
               if (rsp_out_bytes !== e.bytes) begin
                  $display("%0t: out_bytes expected %h, got %h", $time, e.bytes, rsp_out_bytes);
                  fail_count++;
               end
               if (rsp_out_count !== e.count) begin
                  $display("%0t: out_count expected %0d, got %0d", $time, e.count,
                     rsp_out_count);
                  fail_count++;
               end
               if (rsp_out_last !== e.last) begin
                  $display("%0t: out_last expected %b, got %b", $time, e.last, rsp_out_last);
                  fail_count++;
               end
               if (rsp_out_error !== e.error) begin
                  $display("%0t: out_error expected %b, got %b", $time, e.error,
                     rsp_out_error);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               edse_pkg::CSR_SIGHASH: sighash = csr_data;
               edse_pkg::CSR_FORMAT: witness = csr_data[0];
               default: ;
            endcase
         end
         if (start && !busy) absorb_byte(req_in_byte, req_in_last);
      end
      pending = expected_beats.size();
   end

endmodule

// ===== tb/tb_ecdsa_der_signature_encoder.sv =====
`timescale 1ns / 1ps

module tb_ecdsa_der_signature_encoder;

   localparam int ITEM_TARGET   = 270;
   localparam int GAP_END       = (ITEM_TARGET * 3) / 4;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SIG_LOAD      = 64;
   localparam int WITNESS_LOAD  = 97;
   localparam int NO_LAST       = -1;
   localparam logic [1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI = 2'd3;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [7:0]  req_in_byte;
   logic        req_in_last;
   logic        rsp_strobe;
   logic [63:0] rsp_out_bytes;
   logic [3:0]  rsp_out_count;
   logic        rsp_out_last;
   logic        rsp_out_error;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [7:0]  csr_data;

   int   fail_count;
   int   pending;
   int   sent;
   int   cycle_count;
   logic witness;

   ecdsa_der_signature_encoder #(.BYTES_PER_RESULT(8)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_in_byte(req_in_byte), .req_in_last(req_in_last),
      .rsp_strobe(rsp_strobe), .rsp_out_bytes(rsp_out_bytes),
      .rsp_out_count(rsp_out_count), .rsp_out_last(rsp_out_last),
      .rsp_out_error(rsp_out_error),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   ecdsa_der_signature_encoder_checker #(.BYTES_PER_RESULT(8)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_in_byte(req_in_byte), .req_in_last(req_in_last),
      .rsp_strobe(rsp_strobe), .rsp_out_bytes(rsp_out_bytes),
      .rsp_out_count(rsp_out_count), .rsp_out_last(rsp_out_last),
      .rsp_out_error(rsp_out_error),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** ecdsa_der_signature_encoder: FAILED **");
      $finish;
   end

   function automatic logic [255:0] rand_scalar();
      logic [255:0] v;
      for (int i = 0; i < 8; i++) v[32*i +: 32] = $urandom();
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = '1;
         2, 3: v = v >> (8 * $urandom_range(1, 32));
         4: v = edse_pkg::HALF_ORDER + 256'($urandom_range(0, 4)) - 256'd2;
         5: v = edse_pkg::CURVE_ORDER - 256'($urandom_range(0, 3));
         6: v[255] = 1'b0;
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [263:0] rand_key();
      logic [263:0] k;
      for (int i = 0; i < 33; i++) k[8*i +: 8] = 8'($urandom_range(0, 255));
      return k;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic l);
      int gap;
      gap = (sent < GAP_END && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_in_byte <= b;
      req_in_last <= l;
      do @(posedge clock); while (busy);
      sent++;
   endtask

   // bytes first..stop-1 of r, s, key; in_last on byte last_at
   task automatic send_load(input logic [255:0] r, input logic [255:0] s,
                            input logic [263:0] key, input int first, input int stop,
                            input int last_at);
      logic [775:0] blob;
      blob = {r, s, key};
      for (int i = first; i < stop; i++) send_byte(blob[775-8*i -: 8], i == last_at);
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [7:0] data);
      @(negedge clock);
      start <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == edse_pkg::CSR_FORMAT) witness = data[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [255:0] r;
      logic [255:0] s;
      logic [263:0] key;
      int           full;
      int           k;
      int           pick;

      reset = 1'b1;
      start = 1'b0;
      req_in_byte = 8'h00;
      req_in_last = 1'b0;
      csr_valid = 1'b0;
      csr_index = edse_pkg::CSR_SIGHASH;
      csr_data = 8'h00;
      sent = 0;
      witness = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings, r stripped to one byte, zero s
      send_load(256'd1, '0, rand_key(), 0, SIG_LOAD, SIG_LOAD - 1);
      // early last on first byte
      send_load(rand_scalar(), rand_scalar(), rand_key(), 0, 1, 0);
      drain();
      write_csr(edse_pkg::CSR_SIGHASH, 8'h00);
      // plain load extended into a witness load mid-way, padded r, high s
      r = {8'h80, 248'd0};
      s = edse_pkg::HALF_ORDER + 256'd1;
      key = rand_key();
      send_load(r, s, key, 0, 40, NO_LAST);
      drain();
      write_csr(edse_pkg::CSR_FORMAT, 8'hFF);
      send_load(r, s, key, 40, WITNESS_LOAD, WITNESS_LOAD - 1);
      // counter past the plain length after a format change mid-load
      send_load(rand_scalar(), rand_scalar(), rand_key(), 0, SIG_LOAD, NO_LAST);
      drain();
      write_csr(edse_pkg::CSR_FORMAT, 8'hFE);
      send_byte(8'h5A, 1'b0);
      drain();
      write_csr(CSR_SPARE_LO, 8'hA5);
      write_csr(CSR_SPARE_HI, 8'h5A);
      write_csr(edse_pkg::CSR_SIGHASH, 8'h01);

      while (sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 19);
         if (pick < 4) begin
            drain();
            write_csr(edse_pkg::CSR_SIGHASH, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 1)
               write_csr(edse_pkg::CSR_FORMAT, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 5) == 0)
               write_csr($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI,
                  8'($urandom_range(0, 255)));
         end else if (pick < 6) begin
            drain();
         end
         r = rand_scalar();
         s = rand_scalar();
         key = rand_key();
         full = witness ? WITNESS_LOAD : SIG_LOAD;
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            send_load(r, s, key, 0, full, full - 1);
         end else if (pick < 16) begin
            k = $urandom_range(0, full - 2);
            send_load(r, s, key, 0, k + 1, k);
         end else if (pick < 18) begin
            send_load(r, s, key, 0, full, NO_LAST);
         end else begin
            repeat ($urandom_range(1, 4))
               send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("** ecdsa_der_signature_encoder: PASSED **");
      end else begin
         $display("** ecdsa_der_signature_encoder: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/edse_pkg.sv
rtl/edse_ctrl.sv
rtl/edse_dpath.sv
rtl/ecdsa_der_signature_encoder.sv
tb/ecdsa_der_signature_encoder_checker.sv
tb/tb_ecdsa_der_signature_encoder.sv
